[sv/lbsr_pkg.sv]
package lbsr_pkg;

    localparam int MAX_WIDTH_DEF   = 128;
    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int COLOUR_BITS_DEF = 16;

    localparam int COORD_W    = 16;
    localparam int PAINT_W    = 16;
    localparam int SW_W       = 8;
    localparam int SH_W       = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CALC_W     = 18;

    localparam logic [SW_W-1:0] SW_RESET = 8'd128;
    localparam logic [SH_W-1:0] SH_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_ORIENT = 8'b0000_0100,
        S_ORDER  = 8'b0000_1000,
        S_STEP   = 8'b0001_0000,
        S_FLUSH  = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

[sv/line_and_box_span_rasterizer_unit.sv]
// Span rasterizer for lines and filled boxes. Each accepted command is turned into one span
// per covered display row, in rising row order, with o_last_span set on the final beat; a
// command that covers nothing gives no beat. The input is taken only when the sequencer is
// idle. A rejected command returns to idle after the check; a box goes straight from the
// check to emitting its spans. A line passes the check, orient and order setup states, then
// takes one Bresenham step per pixel along its major axis (major delta plus one pixels),
// a flush of the last run into the row table, and for each covered row a read of the row
// table and an emit. Output backpressure holds the sequencer in the emit state. Screen size
// registers are written through the config channel, which is always ready; the height
// register keeps the low seven bits of the written value, and values above the build
// maximum are clamped to it.
module line_and_box_span_rasterizer_unit #(
    parameter int MAX_WIDTH   = lbsr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = lbsr_pkg::MAX_HEIGHT_DEF,
    parameter int COLOUR_BITS = lbsr_pkg::COLOUR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lbsr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lbsr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic signed [lbsr_pkg::COORD_W-1:0]   i_first_x,
    input  logic signed [lbsr_pkg::COORD_W-1:0]   i_first_y,
    input  logic signed [lbsr_pkg::COORD_W-1:0]   i_second_x,
    input  logic signed [lbsr_pkg::COORD_W-1:0]   i_second_y,
    input  logic [lbsr_pkg::PAINT_W-1:0]          i_paint,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [$clog2(MAX_HEIGHT)-1:0]         o_span_row,
    output logic [$clog2(MAX_WIDTH)-1:0]          o_span_start,
    output logic [$clog2(MAX_WIDTH)-1:0]          o_span_end,
    output logic [COLOUR_BITS-1:0]                o_span_paint,
    output logic                                  o_last_span
);
    import lbsr_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CW    = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int EW    = CW + 2;

    t_state                    r_state, n_state;
    logic [SW_W-1:0]           r_sw;
    logic [SH_W-1:0]           r_sh;
    logic                      r_mode, n_mode;
    logic signed [COORD_W-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    logic [COLOUR_BITS-1:0]    r_paint, n_paint;

    logic [CW-1:0]             r_x, n_x, r_y, n_y, r_xe, n_xe, r_ye, n_ye;
    logic [CW-1:0]             r_dx, n_dx, r_dy, n_dy;
    logic signed [EW-1:0]      r_err, n_err;
    logic                      r_steep, n_steep, r_ydn, n_ydn, r_first, n_first;

    logic [ROW_W-1:0]          r_run_row, n_run_row, r_rlo, n_rlo, r_rhi, n_rhi;
    logic [ROW_W-1:0]          r_srow, n_srow;
    logic [COL_W-1:0]          r_run_lo, n_run_lo, r_run_hi, n_run_hi;

    logic                      r_ovalid, n_ovalid, r_olast, n_olast;
    logic [ROW_W-1:0]          r_orow, n_orow;
    logic [COL_W-1:0]          r_ostart, n_ostart, r_oend, n_oend;
    logic [COLOUR_BITS-1:0]    r_opaint, n_opaint;

    t_mem_ctl                  mem_ctl;
    logic [COL_W-1:0]          mem_lo, mem_hi;

    logic signed [CALC_W-1:0]  w_s, h_s, ax_s, ay_s, bx_s, by_s, bxc_s, byc_s;
    logic                      line_bad, box_bad, slot_free;
    logic [31:0]               paint_ext;

    logic signed [CW:0]        sdx, sdy;
    logic [CW-1:0]             adx, ady;
    logic                      steep;
    logic                      swap;
    logic [CW-1:0]             ox, oy, oxe, oye, odx, ody;

    logic [ROW_W-1:0]          pr;
    logic [COL_W-1:0]          pc;
    logic signed [EW-1:0]      e1;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign slot_free   = ~r_ovalid | i_out_ready;
    assign paint_ext   = 32'(i_paint);

    assign w_s  = (CALC_W'(r_sw) > CALC_W'(MAX_WIDTH))  ? CALC_W'(MAX_WIDTH)  : CALC_W'(r_sw);
    assign h_s  = (CALC_W'(r_sh) > CALC_W'(MAX_HEIGHT)) ? CALC_W'(MAX_HEIGHT) : CALC_W'(r_sh);
    assign ax_s = CALC_W'(r_ax);
    assign ay_s = CALC_W'(r_ay);
    assign bx_s = CALC_W'(r_bx);
    assign by_s = CALC_W'(r_by);

    assign line_bad = (ax_s < 0) || (ax_s >= w_s) || (bx_s < 0) || (bx_s >= w_s) ||
                      (ay_s < 0) || (ay_s >= h_s) || (by_s < 0) || (by_s >= h_s);
    assign box_bad  = (ax_s < 0) || (ay_s < 0) || (bx_s <= ax_s) || (by_s <= ay_s) ||
                      (ax_s >= w_s) || (ay_s >= h_s);
    assign bxc_s    = (bx_s > w_s - CALC_W'(1)) ? (w_s - CALC_W'(1)) : bx_s;
    assign byc_s    = (by_s > h_s - CALC_W'(1)) ? (h_s - CALC_W'(1)) : by_s;

    assign sdx   = $signed({1'b0, r_bx[CW-1:0]}) - $signed({1'b0, r_ax[CW-1:0]});
    assign sdy   = $signed({1'b0, r_by[CW-1:0]}) - $signed({1'b0, r_ay[CW-1:0]});
    assign adx   = sdx[CW] ? CW'(-sdx) : CW'(sdx);
    assign ady   = sdy[CW] ? CW'(-sdy) : CW'(sdy);
    assign steep = (ady > adx);

    assign swap = (r_x > r_xe);
    assign ox   = swap ? r_xe : r_x;
    assign oy   = swap ? r_ye : r_y;
    assign oxe  = swap ? r_x  : r_xe;
    assign oye  = swap ? r_y  : r_ye;
    assign odx  = oxe - ox;
    assign ody  = (oye > oy) ? (oye - oy) : (oy - oye);

    assign pr = r_steep ? r_x[ROW_W-1:0] : r_y[ROW_W-1:0];
    assign pc = r_steep ? r_y[COL_W-1:0] : r_x[COL_W-1:0];
    assign e1 = r_err - EW'(r_dy);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_bx      = r_bx;
        n_by      = r_by;
        n_paint   = r_paint;
        n_x       = r_x;
        n_y       = r_y;
        n_xe      = r_xe;
        n_ye      = r_ye;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_err     = r_err;
        n_steep   = r_steep;
        n_ydn     = r_ydn;
        n_first   = r_first;
        n_run_row = r_run_row;
        n_run_lo  = r_run_lo;
        n_run_hi  = r_run_hi;
        n_rlo     = r_rlo;
        n_rhi     = r_rhi;
        n_srow    = r_srow;
        n_ovalid  = r_ovalid & ~i_out_ready;
        n_orow    = r_orow;
        n_ostart  = r_ostart;
        n_oend    = r_oend;
        n_olast   = r_olast;
        n_opaint  = r_opaint;
        mem_ctl   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_ax    = i_first_x;
                    n_ay    = i_first_y;
                    n_bx    = i_second_x;
                    n_by    = i_second_y;
                    n_paint = paint_ext[COLOUR_BITS-1:0];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_mode) begin
                    if (box_bad) begin
                        n_state = S_IDLE;
                    end else begin
                        n_srow   = ay_s[ROW_W-1:0];
                        n_rhi    = byc_s[ROW_W-1:0];
                        n_run_lo = ax_s[COL_W-1:0];
                        n_run_hi = bxc_s[COL_W-1:0];
                        n_state  = S_EMIT;
                    end
                end else begin
                    n_state = line_bad ? S_IDLE : S_ORIENT;
                end
            end
            S_ORIENT: begin
                n_steep = steep;
                n_x     = steep ? r_ay[CW-1:0] : r_ax[CW-1:0];
                n_y     = steep ? r_ax[CW-1:0] : r_ay[CW-1:0];
                n_xe    = steep ? r_by[CW-1:0] : r_bx[CW-1:0];
                n_ye    = steep ? r_bx[CW-1:0] : r_by[CW-1:0];
                n_state = S_ORDER;
            end
            S_ORDER: begin
                n_x     = ox;
                n_y     = oy;
                n_xe    = oxe;
                n_ye    = oye;
                n_dx    = odx;
                n_dy    = ody;
                n_err   = EW'(odx >> 1);
                n_ydn   = (oy > oye);
                n_first = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_first || (pr != r_run_row)) begin
                    mem_ctl.wr = ~r_first;
                    n_run_row  = pr;
                    n_run_lo   = pc;
                    n_run_hi   = pc;
                    if (r_first) begin
                        n_rlo = pr;
                        n_rhi = pr;
                    end else begin
                        n_rlo = (pr < r_rlo) ? pr : r_rlo;
                        n_rhi = (pr > r_rhi) ? pr : r_rhi;
                    end
                end else begin
                    n_run_lo = (pc < r_run_lo) ? pc : r_run_lo;
                    n_run_hi = (pc > r_run_hi) ? pc : r_run_hi;
                end
                n_first = 1'b0;
                if (e1[EW-1]) begin
                    n_y   = r_ydn ? (r_y - 1'b1) : (r_y + 1'b1);
                    n_err = e1 + EW'(r_dx);
                end else begin
                    n_err = e1;
                end
                if (r_x == r_xe) begin
                    n_state = S_FLUSH;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            S_FLUSH: begin
                mem_ctl.wr = 1'b1;
                n_srow     = r_rlo;
                n_state    = S_READ;
            end
            S_READ: begin
                mem_ctl.rd = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = r_srow;
                    n_ostart = r_mode ? r_run_lo : mem_lo;
                    n_oend   = r_mode ? r_run_hi : mem_hi;
                    n_olast  = (r_srow == r_rhi);
                    n_opaint = r_paint;
                    if (r_srow == r_rhi) begin
                        n_state = S_IDLE;
                    end else begin
                        n_srow  = r_srow + 1'b1;
                        n_state = r_mode ? S_EMIT : S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sw     <= SW_RESET;
            r_sh     <= SH_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_sw <= i_cfg_data[SW_W-1:0];
                    CFG_SCREEN_HEIGHT: r_sh <= i_cfg_data[SH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_bx      <= n_bx;
        r_by      <= n_by;
        r_paint   <= n_paint;
        r_x       <= n_x;
        r_y       <= n_y;
        r_xe      <= n_xe;
        r_ye      <= n_ye;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_err     <= n_err;
        r_steep   <= n_steep;
        r_ydn     <= n_ydn;
        r_first   <= n_first;
        r_run_row <= n_run_row;
        r_run_lo  <= n_run_lo;
        r_run_hi  <= n_run_hi;
        r_rlo     <= n_rlo;
        r_rhi     <= n_rhi;
        r_srow    <= n_srow;
        r_orow    <= n_orow;
        r_ostart  <= n_ostart;
        r_oend    <= n_oend;
        r_olast   <= n_olast;
        r_opaint  <= n_opaint;
    end

    lbsr_row_mem #(
        .DEPTH (MAX_HEIGHT),
        .COL_W (COL_W)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (r_run_row),
        .i_wlo   (r_run_lo),
        .i_whi   (r_run_hi),
        .i_raddr (r_srow),
        .o_rlo   (mem_lo),
        .o_rhi   (mem_hi)
    );

    assign o_out_valid  = r_ovalid;
    assign o_span_row   = r_orow;
    assign o_span_start = r_ostart;
    assign o_span_end   = r_oend;
    assign o_span_paint = r_opaint;
    assign o_last_span  = r_olast;

endmodule

[sv/lbsr_row_mem.sv]
module lbsr_row_mem #(
    parameter int DEPTH = lbsr_pkg::MAX_HEIGHT_DEF,
    parameter int COL_W = 7
) (
    input  logic                     i_clk,
    input  lbsr_pkg::t_mem_ctl       i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [COL_W-1:0]         i_wlo,
    input  logic [COL_W-1:0]         i_whi,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [COL_W-1:0]         o_rlo,
    output logic [COL_W-1:0]         o_rhi
);
    import lbsr_pkg::*;

    logic [2*COL_W-1:0] r_mem [DEPTH];
    logic [2*COL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= {i_wlo, i_whi};
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rlo = r_rdata[2*COL_W-1:COL_W];
    assign o_rhi = r_rdata[COL_W-1:0];

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbsr_pkg::*;

    localparam int ROW_W = $clog2(MAX_HEIGHT_DEF);
    localparam int COL_W = $clog2(MAX_WIDTH_DEF);

    localparam logic MODE_LINE = 1'b0;
    localparam logic MODE_BOX  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;

    localparam int N_DIRECTED      = 25;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int SETTLE_CYCLES   = 250;
    localparam int HOLDOFF_CYCLES  = 600;
    localparam int WATCHDOG_LIMIT  = 20000;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_RUN
    } t_exp_kind;

    typedef struct {
        logic                      mode;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic [PAINT_W-1:0]        paint;
    } t_cmd;

    typedef struct {
        t_cmd      c;
        t_exp_kind kind;
        int        row_first;
        int        row_last;
        int        col_first;
        int        col_last;
    } t_dir_row;

    typedef struct {
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col_lo;
        logic [COL_W-1:0]           col_hi;
        logic [COLOUR_BITS_DEF-1:0] paint;
        logic                       last_span;
    } t_span;

    typedef struct {
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
    } t_screen_cfg;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_mode;
    logic signed [COORD_W-1:0] i_first_x;
    logic signed [COORD_W-1:0] i_first_y;
    logic signed [COORD_W-1:0] i_second_x;
    logic signed [COORD_W-1:0] i_second_y;
    logic [PAINT_W-1:0]        i_paint;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [ROW_W-1:0]          o_span_row;
    logic [COL_W-1:0]          o_span_start;
    logic [COL_W-1:0]          o_span_end;
    logic [COLOUR_BITS_DEF-1:0] o_span_paint;
    logic                      o_last_span;

    logic [SW_W-1:0] cfg_width;
    logic [SH_W-1:0] cfg_height;
    t_span           pending_spans[$];
    bit              failed;
    bit              holdoff_req;
    bit              holdoff_done;
    int              burst_left;
    int              stall_cycles;

    t_screen_cfg phase_cfg [N_PHASES] = '{
        '{8'd255, 8'd127},
        '{8'd1,   8'd1},
        '{8'd0,   8'd64},
        '{8'd128, 8'd0},
        '{8'd37,  8'd19},
        '{8'd2,   8'd200},
        '{8'd100, 8'd45},
        '{8'd128, 8'd64}
    };

    t_dir_row directed_rows [N_DIRECTED] = '{
        '{'{MODE_LINE, 16'd0,    16'd0,    16'd0,    16'd0,    16'hFFFF}, EXP_RUN, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd127,  16'd63,   16'd127,  16'd63,   16'h0000}, EXP_RUN, 63, 63, 127, 127},
        '{'{MODE_LINE, 16'd0,    16'd0,    16'd128,  16'd0,    16'h1234}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd0,    16'hFFFF, 16'd5,    16'd5,    16'h4321}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'h8000, 16'd0,    16'd3,    16'd3,    16'h0F0F}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd0,    16'd0,    16'd3,    16'h7FFF, 16'hF0F0}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd0,    16'd5,    16'd127,  16'd5,    16'hAAAA}, EXP_RUN, 5, 5, 0, 127},
        '{'{MODE_LINE, 16'd3,    16'd63,   16'd3,    16'd0,    16'h5555}, EXP_RUN, 0, 63, 3, 3},
        '{'{MODE_LINE, 16'd0,    16'd0,    16'd63,   16'd63,   16'h00FF}, EXP_MODEL, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd10,   16'd60,   16'd20,   16'd2,    16'hFF00}, EXP_MODEL, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd5,    16'd40,   16'd120,  16'd10,   16'h8001}, EXP_MODEL, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd100,  16'd3,    16'd2,    16'd50,   16'h7FFE}, EXP_MODEL, 0, 0, 0, 0},
        '{'{MODE_LINE, 16'd127,  16'd0,    16'd0,    16'd63,   16'hC3C3}, EXP_MODEL, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'd0,    16'd0,    16'd127,  16'd63,   16'hFFFF}, EXP_RUN, 0, 63, 0, 127},
        '{'{MODE_BOX,  16'd100,  16'd50,   16'h7FFF, 16'h7FFF, 16'h0001}, EXP_RUN, 50, 63, 100, 127},
        '{'{MODE_BOX,  16'd10,   16'd10,   16'd10,   16'd20,   16'h2222}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'd10,   16'd10,   16'd20,   16'd9,    16'h3333}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'hFFFF, 16'd0,    16'd5,    16'd5,    16'h4444}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'd128,  16'd0,    16'd200,  16'd10,   16'h5A5A}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'd0,    16'd64,   16'd10,   16'd70,   16'hA5A5}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'd0,    16'd0,    16'h8000, 16'd5,    16'h6666}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7777}, EXP_NONE, 0, 0, 0, 0},
        '{'{MODE_BOX,  16'd4,    16'd7,    16'd9,    16'd8,    16'h8888}, EXP_RUN, 7, 8, 4, 9},
        '{'{MODE_BOX,  16'd126,  16'd62,   16'd127,  16'd63,   16'h9999}, EXP_RUN, 62, 63, 126, 127},
        '{'{MODE_LINE, 16'd0,    16'd63,   16'd127,  16'd63,   16'h5555}, EXP_RUN, 63, 63, 0, 127}
    };

    line_and_box_span_rasterizer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_paint      (i_paint),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_span_row   (o_span_row),
        .o_span_start (o_span_start),
        .o_span_end   (o_span_end),
        .o_span_paint (o_span_paint),
        .o_last_span  (o_last_span)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_width();
        return (cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (cfg_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cfg_height);
    endfunction

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void rasterize_cmd(input t_cmd c);
        bit    hit [MAX_HEIGHT_DEF];
        int    lo [MAX_HEIGHT_DEF];
        int    hi [MAX_HEIGHT_DEF];
        int    w, h, ax, ay, bx, by, t, dx, dy, err, ystep, x, y, px, py, last_row;
        bit    steep;
        t_span s;
        w = eff_width();
        h = eff_height();
        ax = c.first_x;
        ay = c.first_y;
        bx = c.second_x;
        by = c.second_y;
        last_row = -1;
        for (int r = 0; r < MAX_HEIGHT_DEF; r++) begin
            hit[r] = 1'b0;
            lo[r] = 0;
            hi[r] = 0;
        end
        if (c.mode == MODE_BOX) begin
            if (ax >= 0 && ay >= 0 && bx > ax && by > ay && ax < w && ay < h) begin
                if (bx > w - 1) bx = w - 1;
                if (by > h - 1) by = h - 1;
                for (y = ay; y <= by; y++) begin
                    hit[y] = 1'b1;
                    lo[y] = ax;
                    hi[y] = bx;
                end
            end
        end else if (ax >= 0 && ax < w && bx >= 0 && bx < w &&
                     ay >= 0 && ay < h && by >= 0 && by < h) begin
            steep = mag(by - ay) > mag(bx - ax);
            if (steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = mag(by - ay);
            err = dx / 2;
            ystep = (ay < by) ? 1 : -1;
            y = ay;
            for (x = ax; x <= bx; x++) begin
                if (steep) begin
                    px = y;
                    py = x;
                end else begin
                    px = x;
                    py = y;
                end
                if (py >= 0 && py < h) begin
                    if (!hit[py]) begin
                        hit[py] = 1'b1;
                        lo[py] = px;
                        hi[py] = px;
                    end else begin
                        if (px < lo[py]) lo[py] = px;
                        if (px > hi[py]) hi[py] = px;
                    end
                end
                err -= dy;
                if (err < 0) begin
                    y += ystep;
                    err += dx;
                end
            end
        end
        for (int r = 0; r < MAX_HEIGHT_DEF; r++) begin
            if (hit[r]) last_row = r;
        end
        for (int r = 0; r < MAX_HEIGHT_DEF; r++) begin
            if (hit[r]) begin
                s.row = ROW_W'(r);
                s.col_lo = COL_W'(lo[r]);
                s.col_hi = COL_W'(hi[r]);
                s.paint = c.paint;
                s.last_span = (r == last_row);
                pending_spans.push_back(s);
            end
        end
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   gw, gh, pick, v;
        gw = (eff_width() == 0) ? MAX_WIDTH_DEF : eff_width();
        gh = (eff_height() == 0) ? MAX_HEIGHT_DEF : eff_height();
        c.paint = PAINT_W'($urandom);
        c.mode = 1'($urandom_range(0, 1));
        c.first_x = COORD_W'($urandom_range(0, gw - 1));
        c.first_y = COORD_W'($urandom_range(0, gh - 1));
        pick = $urandom_range(0, 9);
        if (pick <= 3 || (pick == 7 && c.mode == MODE_LINE)) begin
            if (pick <= 3) c.mode = MODE_LINE;
            c.second_x = COORD_W'($urandom_range(0, gw - 1));
            c.second_y = COORD_W'($urandom_range(0, gh - 1));
        end else if (pick <= 7) begin
            if (pick <= 6) c.mode = MODE_BOX;
            c.second_x = COORD_W'(int'(c.first_x) + $urandom_range(1, 48));
            c.second_y = COORD_W'(int'(c.first_y) + $urandom_range(1, 24));
        end else begin
            c.first_x = COORD_W'($urandom);
            c.first_y = COORD_W'($urandom);
            c.second_x = COORD_W'($urandom);
            c.second_y = COORD_W'($urandom);
        end
        if (pick == 7) begin
            case ($urandom_range(0, 4))
                0: v = -1;
                1: v = gw;
                2: v = gh;
                3: v = -32768;
                default: v = 32767;
            endcase
            case ($urandom_range(0, 3))
                0: c.first_x = COORD_W'(v);
                1: c.first_y = COORD_W'(v);
                2: c.second_x = COORD_W'(v);
                default: c.second_y = COORD_W'(v);
            endcase
        end
        return c;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    task automatic offer(input t_cmd c, input t_exp_kind kind, input int row_first,
                         input int row_last, input int col_first, input int col_last);
        t_span s;
        i_in_valid <= 1'b1;
        i_mode <= c.mode;
        i_first_x <= c.first_x;
        i_first_y <= c.first_y;
        i_second_x <= c.second_x;
        i_second_y <= c.second_y;
        i_paint <= c.paint;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (kind == EXP_MODEL) begin
            rasterize_cmd(c);
        end else if (kind == EXP_RUN) begin
            for (int r = row_first; r <= row_last; r++) begin
                s.row = ROW_W'(r);
                s.col_lo = COL_W'(col_first);
                s.col_hi = COL_W'(col_last);
                s.paint = c.paint;
                s.last_span = (r == row_last);
                pending_spans.push_back(s);
            end
        end
        // hold valid across back-to-back beats, drop it only for a gap
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_SCREEN_WIDTH) begin
            cfg_width = data[SW_W-1:0];
        end else if (idx == CFG_SCREEN_HEIGHT) begin
            cfg_height = data[SH_W-1:0];
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_mode <= MODE_LINE;
        i_first_x <= '0;
        i_first_y <= '0;
        i_second_x <= '0;
        i_second_y <= '0;
        i_paint <= '0;
        cfg_width = SW_RESET;
        cfg_height = SH_RESET;
        failed = 1'b0;
        holdoff_req = 1'b0;
        holdoff_done = 1'b0;
        burst_left = 4;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[k]) begin
            offer(directed_rows[k].c, directed_rows[k].kind, directed_rows[k].row_first,
                  directed_rows[k].row_last, directed_rows[k].col_first,
                  directed_rows[k].col_last);
        end
        drain();
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_SCREEN_WIDTH, phase_cfg[p].width);
            write_reg(CFG_SCREEN_HEIGHT, phase_cfg[p].height);
            if (p == 2) write_reg(CFG_UNUSED, 8'hFF);
            i_cfg_valid <= 1'b0;
            if (p == 0) holdoff_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                offer(random_cmd(), EXP_MODEL, 0, 0, 0, 0);
            end
            drain();
        end
        if (!failed && pending_spans.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        int style;
        int stretch;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holdoff_req && !holdoff_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_done = 1'b1;
            end
            style = $urandom_range(0, 3);
            stretch = $urandom_range(16, 160);
            repeat (stretch) begin
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_spans.size() == 0) begin
                $display("%0t: unexpected span: expected none, actual row %0d cols %0d..%0d",
                         $time, o_span_row, o_span_start, o_span_end);
                failed = 1'b1;
            end else begin
                want = pending_spans.pop_front();
                compare_field("span_row", 32'(want.row), 32'(o_span_row));
                compare_field("span_start", 32'(want.col_lo), 32'(o_span_start));
                compare_field("span_end", 32'(want.col_hi), 32'(o_span_end));
                compare_field("span_paint", 32'(want.paint), 32'(o_span_paint));
                compare_field("last_span", 32'(want.last_span), 32'(o_last_span));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, stall_cycles);
            $display("tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
